@@ hdl/sfr_pkg.sv @@
// Shared types, constants and register codes of the stream find-and-replace block.
package sfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 4;
  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PatternMaxDefault = 8;
  localparam int unsigned ReplacementMaxDefault = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegPatternBytes     = 2'd0,
    RegPatternLength    = 2'd1,
    RegReplacementBytes = 2'd2,
    RegReplacementLength = 2'd3
  } cfg_reg_e;

  // Control part of one queued command; the data bytes travel beside it.
  typedef struct packed {
    logic [LenW-1:0] rep_cnt;
    logic [LenW-1:0] dat_cnt;
    logic            last;
  } sfr_ctl_t;

endpackage

@@ hdl/sfr_if.sv @@
// Request channels of the block: input byte stream and rewritten output stream.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input out_last,
                output ready);
endinterface

@@ hdl/sfr_cmd_fifo.sv @@
// Small command queue that decouples the match front from the output back.
module sfr_cmd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointers wrap at the queue depth.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule

@@ hdl/sfr_front.sv @@
// Front end: keeps the byte window, decides match or pass per byte, issues commands.
module sfr_front #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACEMENT_MAX = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sfr_in_if.sink                            in_i,
  input  logic [sfr_pkg::CfgW-1:0]          pat_bytes_i,
  input  logic [sfr_pkg::LenW-1:0]          pat_len_i,
  input  logic [sfr_pkg::LenW-1:0]          rep_len_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output sfr_pkg::sfr_ctl_t                 q_ctl_o,
  output logic [PATTERN_MAX-1:0][7:0]       q_data_o
);
  import sfr_pkg::*;

  localparam logic [LenW-1:0] PMax = LenW'(PATTERN_MAX);
  localparam logic [LenW-1:0] RMax = LenW'(REPLACEMENT_MAX);

  logic [PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [LenW-1:0]             wc_q, wc_d;

  logic [PATTERN_MAX-1:0][7:0] wa, sh1, shp;
  logic [LenW-1:0]             plen, rlen, cnt1, cnt2;
  logic                        decide, mism, hit, accept;
  logic [LenW:0]               total;

  assign accept      = in_i.valid && !q_full_i;
  assign in_i.ready  = !q_full_i;

  // Saturate the configured lengths; an empty pattern counts as one byte.
  always_comb begin
    if (pat_len_i == '0) begin
      plen = LenW'(1);
    end else if (pat_len_i > PMax) begin
      plen = PMax;
    end else begin
      plen = pat_len_i;
    end
    rlen = (rep_len_i > RMax) ? RMax : rep_len_i;
  end

  // Append the new byte unless the window is already full.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      wa[i] = (LenW'(i) == wc_q) ? in_i.in_byte : win_q[i];
    end
    cnt1 = (wc_q < PMax) ? wc_q + 1'b1 : wc_q;
  end

  // Compare the oldest plen bytes with the pattern.
  always_comb begin
    mism = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((LenW'(i) < plen) && (wa[i] != pat_bytes_i[8*i +: 8])) begin
        mism = 1'b1;
      end
    end
    decide = (cnt1 >= plen);
    hit    = decide && !mism;
  end

  // Window moved by one byte and by the pattern length.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      sh1[i] = (i + 1 < PATTERN_MAX) ? wa[(i + 1) % PATTERN_MAX] : 8'h00;
      shp[i] = 8'h00;
      for (int k = 1; k <= PATTERN_MAX; k++) begin
        if ((plen == LenW'(k)) && (i + k < PATTERN_MAX)) begin
          shp[i] = wa[(i + k) % PATTERN_MAX];
        end
      end
    end
  end

  // Build the command and the next window state.
  always_comb begin
    if (hit) begin
      cnt2 = cnt1 - plen;
    end else if (decide) begin
      cnt2 = cnt1 - 1'b1;
    end else begin
      cnt2 = cnt1;
    end

    q_ctl_o.last    = in_i.in_last;
    q_ctl_o.rep_cnt = hit ? rlen : '0;
    q_data_o        = hit ? shp : wa;
    if (hit) begin
      q_ctl_o.dat_cnt = in_i.in_last ? cnt2 : '0;
    end else if (decide) begin
      q_ctl_o.dat_cnt = in_i.in_last ? cnt1 : LenW'(1);
    end else begin
      q_ctl_o.dat_cnt = in_i.in_last ? cnt1 : '0;
    end
    total    = {1'b0, q_ctl_o.rep_cnt} + {1'b0, q_ctl_o.dat_cnt};
    q_push_o = accept && ((total != '0) || in_i.in_last);

    wc_d  = wc_q;
    win_d = win_q;
    if (accept) begin
      wc_d = in_i.in_last ? '0 : cnt2;
      if (hit) begin
        win_d = shp;
      end else if (decide) begin
        win_d = sh1;
      end else begin
        win_d = wa;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= '0;
    end else begin
      wc_q <= wc_d;
    end
  end

  // Window bytes are payload; only the fill count is reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end
endmodule

@@ hdl/sfr_back.sv @@
// Back end: expands queued commands into output bytes behind an output register.
module sfr_back #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACEMENT_MAX = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sfr_pkg::CfgW-1:0]      rep_bytes_i,
  input  logic                          q_empty_i,
  input  sfr_pkg::sfr_ctl_t             q_ctl_i,
  input  logic [PATTERN_MAX-1:0][7:0]   q_data_i,
  output logic                          q_pop_o,
  sfr_out_if.source                     out_o
);
  import sfr_pkg::*;

  logic                        act_q, act_d;
  logic [LenW-1:0]             rep_left_q, rep_left_d, dat_left_q, dat_left_d;
  logic                        last_q, last_d, bare_q, bare_d;
  logic [CfgW-1:0]             rep_sh_q, rep_sh_d;
  logic [PATTERN_MAX-1:0][7:0] dat_sh_q, dat_sh_d;

  logic       ov_q, ov_d, obv_q, obv_d, ol_q, ol_d;
  logic [7:0] ob_q, ob_d;

  logic       out_free, take, gen_final, can_load;
  logic [7:0] gen_byte;
  logic       gen_bv;
  logic [LenW:0] left_sum;

  // Current byte of the active command.
  always_comb begin
    left_sum  = {1'b0, rep_left_q} + {1'b0, dat_left_q};
    gen_final = bare_q || (left_sum == (LenW + 1)'(1));
    if (rep_left_q != '0) begin
      gen_byte = rep_sh_q[7:0];
      gen_bv   = 1'b1;
    end else if (dat_left_q != '0) begin
      gen_byte = dat_sh_q[0];
      gen_bv   = 1'b1;
    end else begin
      gen_byte = 8'h00;
      gen_bv   = 1'b0;
    end
    out_free = !ov_q || out_o.ready;
    take     = act_q && out_free;
    can_load = !act_q || (take && gen_final);
    q_pop_o  = can_load && !q_empty_i;
  end

  // Sequencer: step through replacement bytes, then data bytes, then load next.
  always_comb begin
    act_d      = act_q;
    rep_left_d = rep_left_q;
    dat_left_d = dat_left_q;
    rep_sh_d   = rep_sh_q;
    dat_sh_d   = dat_sh_q;
    last_d     = last_q;
    bare_d     = bare_q;
    if (q_pop_o) begin
      act_d      = 1'b1;
      rep_left_d = q_ctl_i.rep_cnt;
      dat_left_d = q_ctl_i.dat_cnt;
      rep_sh_d   = rep_bytes_i;
      dat_sh_d   = q_data_i;
      last_d     = q_ctl_i.last;
      bare_d     = (q_ctl_i.rep_cnt == '0) && (q_ctl_i.dat_cnt == '0);
    end else if (take && gen_final) begin
      act_d = 1'b0;
    end else if (take) begin
      if (rep_left_q != '0) begin
        rep_left_d = rep_left_q - 1'b1;
        rep_sh_d   = rep_sh_q >> 8;
      end else begin
        dat_left_d = dat_left_q - 1'b1;
        dat_sh_d   = dat_sh_q >> 8;
      end
    end
  end

  // Output register: loads whenever it is free and a command is active.
  always_comb begin
    ov_d  = ov_q;
    ob_d  = ob_q;
    obv_d = obv_q;
    ol_d  = ol_q;
    if (take) begin
      ov_d  = 1'b1;
      ob_d  = gen_byte;
      obv_d = gen_bv;
      ol_d  = gen_final && last_q;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      rep_left_q <= '0;
      dat_left_q <= '0;
      bare_q     <= 1'b0;
      last_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      act_q      <= act_d;
      rep_left_q <= rep_left_d;
      dat_left_q <= dat_left_d;
      bare_q     <= bare_d;
      last_q     <= last_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_sh_q <= rep_sh_d;
    dat_sh_q <= dat_sh_d;
    ob_q     <= ob_d;
    obv_q    <= obv_d;
    ol_q     <= ol_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = ob_q;
  assign out_o.byte_valid = obv_q;
  assign out_o.out_last   = ol_q;

  // A bare end marker only closes a text.
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !obv_q) |-> ol_q)
    else $error("bare end marker without last flag");

  // A bare command holds nothing to emit and ends the text.
  a_bare_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && bare_q) |-> (last_q && (rep_left_q == '0) && (dat_left_q == '0)))
    else $error("bare command carries bytes or lacks last");

  // Replacement bursts never exceed the configured maximum.
  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (rep_left_q <= LenW'(REPLACEMENT_MAX)))
    else $error("replacement count out of range");

  // A byte taken into the output register that is not the command's last leaves the command active.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !gen_final && !q_pop_o) |=> (act_q && !bare_q))
    else $error("command ended early");
endmodule

@@ hdl/stream_find_replace.sv @@
// Top level of the stream find-and-replace block with its configuration registers.
//
// Usage: bytes of a text enter on in_i (valid/ready), in_last marking the final
// byte. Rewritten bytes leave on out_o; every occurrence of the pattern is
// replaced by the replacement, scanning left to right without overlap. A text
// that produces no bytes at all ends in one result with byte_valid low and
// out_last high. Registers are written on cfg_we_i with cfg_idx_i selecting
// pattern bytes, pattern length, replacement bytes or replacement length; write
// them only while no request is in flight.
// Throughput: one input request per cycle while the command queue has room;
// the output side emits one byte per cycle while the receiver is ready, so a
// replacement burst or an end-of-text flush backs up the queue. A byte passes
// the queue, the back end's command registers and the output register to out_o.
// When the receiver stalls, the output register holds and the four-entry queue
// fills before in_i.ready drops. Reset empties the window, queue and output
// register and loads pattern length one, everything else zero.
module stream_find_replace #(
  parameter int unsigned PATTERN_MAX = sfr_pkg::PatternMaxDefault,
  parameter int unsigned REPLACEMENT_MAX = sfr_pkg::ReplacementMaxDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sfr_in_if.sink                      in_i,
  sfr_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfr_pkg::CfgW-1:0]    cfg_data_i
);
  import sfr_pkg::*;

  localparam int unsigned CmdW = $bits(sfr_ctl_t) + PATTERN_MAX * ByteW;

  logic [CfgW-1:0] pat_bytes_q, rep_bytes_q;
  logic [LenW-1:0] pat_len_q, rep_len_q;

  logic                        q_push, q_full, q_pop, q_empty;
  sfr_ctl_t                    push_ctl, pop_ctl;
  logic [PATTERN_MAX-1:0][7:0] push_data, pop_data;
  logic [CmdW-1:0]             q_wdata, q_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegPatternBytes:      pat_bytes_q <= cfg_data_i;
        RegPatternLength:     pat_len_q   <= cfg_data_i[LenW-1:0];
        RegReplacementBytes:  rep_bytes_q <= cfg_data_i;
        RegReplacementLength: rep_len_q   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  sfr_front #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pat_bytes_i (pat_bytes_q),
    .pat_len_i   (pat_len_q),
    .rep_len_i   (rep_len_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_ctl_o     (push_ctl),
    .q_data_o    (push_data)
  );

  assign q_wdata = {push_ctl, push_data};
  assign {pop_ctl, pop_data} = q_rdata;

  sfr_cmd_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  sfr_back #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rep_bytes_i (rep_bytes_q),
    .q_empty_i   (q_empty),
    .q_ctl_i     (pop_ctl),
    .q_data_i    (pop_data),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );
endmodule

@@ dv/stream_find_replace_test.sv @@
// Self-checking testbench of the stream find-and-replace block with its own rewrite predictor.
`timescale 1ns / 100ps

module stream_find_replace_test;
  import sfr_pkg::*;

  localparam int unsigned PatMax = PatternMaxDefault;
  localparam int unsigned RepMax = ReplacementMaxDefault;
  localparam int unsigned TotalItems = 470;
  localparam int unsigned QuietTail = 60;
  localparam int unsigned LongHold = 80;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ResultMax = 16;

  // One rewritten byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } rewrite_t;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    RowWrite,
    RowPredict,
    RowNoResult,
    RowOneResult
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    idx;
    logic [63:0] data;
    logic        last;
    rewrite_t    res;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_data;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stream_find_replace i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor copy of the registers and the scan window.
  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;
  logic [7:0]  scan_win [PatMax];
  int unsigned scan_cnt;
  rewrite_t    step_out [ResultMax];

  rewrite_t    pending_out [$];
  int unsigned fail_cnt;
  int unsigned items_sent;
  bit          quiet;
  bit          hold_req;

  // Expectation typed into the directed table for the request on offer.
  bit          use_typed;
  int unsigned typed_n;
  rewrite_t    typed_res;

  function automatic int unsigned eff_pat_len();
    if (pat_len == 0) return 1;
    if (pat_len > PatMax) return PatMax;
    return 32'(pat_len);
  endfunction

  function automatic void drop_oldest(input int unsigned k);
    int unsigned i;
    if (k >= scan_cnt) begin
      scan_cnt = 0;
    end else begin
      for (i = 0; i + k < scan_cnt; i++) scan_win[i] = scan_win[i + k];
      scan_cnt -= k;
    end
  endfunction

  // Work out the rewritten bytes that one input byte releases.
  function automatic int unsigned rewrite_step(input logic [7:0] b, input logic l);
    int unsigned plen;
    int unsigned rlen;
    int unsigned n;
    int unsigned i;
    bit hit;
    plen = eff_pat_len();
    rlen = (rep_len > RepMax) ? RepMax : rep_len;
    n = 0;
    if (scan_cnt < PatMax) begin
      scan_win[scan_cnt] = b;
      scan_cnt++;
    end
    if (scan_cnt >= plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (scan_win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) begin
          step_out[n] = {rep_bytes[8*i +: 8], 1'b1, 1'b0};
          n++;
        end
        drop_oldest(plen);
      end else begin
        step_out[n] = {scan_win[0], 1'b1, 1'b0};
        n++;
        drop_oldest(1);
      end
    end
    // End of text: flush what is held, or give a bare end marker.
    if (l) begin
      for (i = 0; i < scan_cnt; i++) begin
        step_out[n] = {scan_win[i], 1'b1, 1'b0};
        n++;
      end
      scan_cnt = 0;
      if (n == 0) begin
        step_out[0] = {8'h00, 1'b0, 1'b1};
        n = 1;
      end else begin
        step_out[n-1].last = 1'b1;
      end
    end
    return n;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result checking and prediction, both on accepted requests.
  always @(posedge clk_i) begin : scoreboard
    rewrite_t want;
    int unsigned n;
    int unsigned i;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_out.size() == 0) begin
          $error("unexpected result: out_byte %02h byte_valid %0b out_last %0b",
                 out_ch.out_byte, out_ch.byte_valid, out_ch.out_last);
          fail_cnt++;
        end else begin
          want = pending_out.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
            fail_cnt++;
          end
          if (out_ch.byte_valid !== want.has_data) begin
            $error("byte_valid: expected %0b, got %0b", want.has_data, out_ch.byte_valid);
            fail_cnt++;
          end
          if (out_ch.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_ch.out_last);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        n = rewrite_step(in_ch.in_byte, in_ch.in_last);
        if (use_typed) begin
          if (typed_n != 0) pending_out.insert(pending_out.size(), typed_res);
        end else begin
          for (i = 0; i < n; i++) pending_out.insert(pending_out.size(), step_out[i]);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request, none in the tail.
  initial begin : receiver
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end else begin
        // A long hold request cuts a ready burst short.
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) begin
          @(negedge clk_i);
          if (hold_req) break;
        end
      end
    end
  end

  // Offer one input byte and wait until it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input int unsigned tn, input rewrite_t tr);
    quiet = (items_sent + QuietTail >= TotalItems);
    if (!quiet && !hold_req && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    use_typed = typed;
    typed_n = tn;
    typed_res = tr;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop offering and let every expected result arrive, then let the block settle.
  task automatic drain_out();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      RegPatternBytes:      pat_bytes = data;
      RegPatternLength:     pat_len = data[3:0];
      RegReplacementBytes:  rep_bytes = data;
      RegReplacementLength: rep_len = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    plan_row_t   plan [$];
    logic [8:0]  text_q [$];
    logic [63:0] w;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  b;
    int unsigned phase;
    int unsigned span;
    int unsigned plen;
    int unsigned sel;
    int unsigned cut;
    int unsigned j;
    int unsigned k;
    bit          ended;

    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegPatternBytes;
    cfg_data = '0;
    pat_bytes = '0;
    pat_len = 4'd1;
    rep_bytes = '0;
    rep_len = 4'd0;
    scan_cnt = 0;
    fail_cnt = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    use_typed = 1'b0;
    typed_n = 0;
    typed_res = '0;
    ended = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: reset settings first, where a zero byte is simply deleted.
    plan.insert(plan.size(), {RowNoResult,  RegPatternBytes, 64'h00, 1'b0, {8'h00, 1'b0, 1'b0}});
    plan.insert(plan.size(), {RowOneResult, RegPatternBytes, 64'hFF, 1'b0, {8'hFF, 1'b1, 1'b0}});
    plan.insert(plan.size(), {RowOneResult, RegPatternBytes, 64'h00, 1'b1, {8'h00, 1'b0, 1'b1}});
    plan.insert(plan.size(), {RowOneResult, RegPatternBytes, 64'hA5, 1'b1, {8'hA5, 1'b1, 1'b1}});
    // Three-byte pattern replaced by two bytes; the second text ends inside a partial match.
    plan.insert(plan.size(), {RowWrite, RegPatternBytes,      64'h636261, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowWrite, RegPatternLength,     64'h3,      1'b0, 10'h0});
    plan.insert(plan.size(), {RowWrite, RegReplacementBytes,  64'h5958,   1'b0, 10'h0});
    plan.insert(plan.size(), {RowWrite, RegReplacementLength, 64'h2,      1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h61, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h62, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h63, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h61, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h61, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h62, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h63, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h62, 1'b1, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h61, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h62, 1'b1, 10'h0});
    // Zero pattern length acts as one; an oversized replacement length saturates.
    plan.insert(plan.size(),
                {RowWrite, RegPatternLength, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 10'h0});
    plan.insert(plan.size(),
                {RowWrite, RegReplacementBytes, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowWrite, RegReplacementLength, 64'hF, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h61, 1'b1, 10'h0});
    // Oversized pattern length saturates to the full window; matches are deleted.
    plan.insert(plan.size(),
                {RowWrite, RegPatternBytes, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowWrite, RegPatternLength,     64'h9, 1'b0, 10'h0});
    plan.insert(plan.size(), {RowWrite, RegReplacementLength, 64'h0, 1'b0, 10'h0});
    for (k = 0; k < 8; k++) begin
      plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'hFF, 1'b0, 10'h0});
    end
    plan.insert(plan.size(), {RowPredict, RegPatternBytes, 64'h00, 1'b1, 10'h0});

    foreach (plan[k]) begin
      case (plan[k].kind)
        RowWrite: begin
          drain_out();
          write_reg(plan[k].idx, plan[k].data);
        end
        RowPredict:   send_byte(plan[k].data[7:0], plan[k].last, 1'b0, 0, plan[k].res);
        RowNoResult:  send_byte(plan[k].data[7:0], plan[k].last, 1'b1, 0, plan[k].res);
        RowOneResult: send_byte(plan[k].data[7:0], plan[k].last, 1'b1, 1, plan[k].res);
        default: ;
      endcase
      ended = plan[k].last;
    end

    // Random phases: new settings while idle, texts often left open across a change.
    phase = 0;
    while (items_sent < TotalItems) begin
      drain_out();

      sel = $urandom_range(0, 2);
      s0 = 8'($urandom);
      s1 = 8'($urandom);
      for (j = 0; j < 8; j++) begin
        case (sel)
          0:       w[8*j +: 8] = 8'($urandom);
          1:       w[8*j +: 8] = $urandom_range(0, 1) ? s0 : s1;
          default: w[8*j +: 8] = s0;
        endcase
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(RegPatternBytes, w);

      w = {$urandom, $urandom};
      sel = $urandom_range(0, 19);
      if (sel == 0) w[3:0] = 4'd0;
      else if (sel == 1) w[3:0] = 4'd8;
      else if (sel == 2) w[3:0] = 4'($urandom_range(9, 15));
      else w[3:0] = 4'($urandom_range(1, 6));
      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(RegPatternLength, w);

      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(RegReplacementBytes,
                                                             {$urandom, $urandom});

      w = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel == 0) w[3:0] = 4'd8;
      else if (sel == 1) w[3:0] = 4'($urandom_range(9, 15));
      else if (sel == 2) w[3:0] = 4'd0;
      else w[3:0] = 4'($urandom_range(0, 4));
      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(RegReplacementLength, w);

      // Early on, the receiver holds off long enough for the input side to back up.
      if (phase == 1) hold_req = 1'b1;

      // Texts built mostly from whole and partial pattern copies, with random noise.
      span = $urandom_range(20, 60);
      plen = eff_pat_len();
      text_q.delete();
      while (text_q.size() < span) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) cut = plen;
        else if (sel < 6) cut = $urandom_range(1, plen);
        else cut = 1;
        for (j = 0; j < cut; j++) begin
          if (sel >= 8) b = 8'($urandom);
          else if (sel >= 6) b = pat_bytes[8*$urandom_range(0, plen - 1) +: 8];
          else b = pat_bytes[8*j +: 8];
          text_q.insert(text_q.size(), {1'b0, b});
        end
        if ($urandom_range(0, 5) == 0) text_q[$][8] = 1'b1;
      end
      foreach (text_q[j]) begin
        send_byte(text_q[j][7:0], text_q[j][8], 1'b0, 0, '0);
        ended = text_q[j][8];
      end
      phase++;
    end

    // Close the final text so the window is flushed.
    if (!ended) send_byte(8'($urandom), 1'b1, 1'b0, 0, '0);
    drain_out();

    if (fail_cnt == 0 && pending_out.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog on a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sfr_pkg.sv
hdl/sfr_if.sv
hdl/sfr_cmd_fifo.sv
hdl/sfr_front.sv
hdl/sfr_back.sv
hdl/stream_find_replace.sv
dv/stream_find_replace_test.sv
